FILE: rtl/best_format_match_select_defines.svh
// ----------------------------------------------------------------------------
// best_format_match_select_defines.svh
// Assertion macros used by the checker of the format match block.
// ----------------------------------------------------------------------------
`ifndef BEST_FORMAT_MATCH_SELECT_DEFINES_SVH
`define BEST_FORMAT_MATCH_SELECT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define BFMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define BFMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bfms_pkg.sv
// ----------------------------------------------------------------------------
// bfms_pkg
// Widths, register indexes and reset values of the format match block.
// ----------------------------------------------------------------------------
package bfms_pkg;

    // Largest list the position counter is sized for.
    localparam int MAX_OFFERS = 256;

    // Field widths.
    localparam int FMT_W  = 6;
    localparam int DIM_W  = 13;
    localparam int RATE_W = 18;
    localparam int POS_W  = 8;

    // Position counter stops here; later offers share this position.
    localparam int POS_CAP_INT = (MAX_OFFERS - 1 < 255) ? (MAX_OFFERS - 1) : 255;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

    // Stream payload widths, padded to whole bytes.
    localparam int IN_FIELDS_W  = FMT_W + DIM_W + DIM_W + RATE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = POS_W;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = RATE_W;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WANT_FORMAT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WANT_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WANT_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WANT_RATE   = 3'd3;

    // Register reset values.
    localparam logic [FMT_W-1:0]  WANT_FORMAT_RST = 6'd0;
    localparam logic [DIM_W-1:0]  WANT_WIDTH_RST  = 13'd640;
    localparam logic [DIM_W-1:0]  WANT_HEIGHT_RST = 13'd480;
    localparam logic [RATE_W-1:0] WANT_RATE_RST   = 18'd30000;

endpackage

FILE: rtl/best_format_match_select.sv
// ----------------------------------------------------------------------------
// best_format_match_select
// Picks the offered camera format closest to the requested one.
// ----------------------------------------------------------------------------
// Offers enter on the s_axis channel, one item per offer, with tlast on the
// final offer of a list. Only offers whose format code equals want_format
// take part; among them the one with the smallest height gap, then width
// gap, then rate gap wins, and the earlier offer keeps a full tie.
// After the last offer one result item leaves on m_axis: tuser carries the
// found flag and tdata the zero-based position of the winner (0 if none).
// An offer is taken into an input register and compared there against the
// running best; when a last offer moves on, the result lands in the output
// register. One offer per cycle is sustained unless a last offer waits on a
// stalled result; the limit is the single compare and update loop on the
// best-so-far registers.
// The cfg channel is always ready and writes the four request registers;
// it is meant for use between lists.
// Reset clears the list state and loads the request defaults (format 0,
// 640 x 480, 30.000 fps). While m_axis is stalled with a result pending,
// non-last offers still flow; a last offer waits in the input register and
// s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module best_format_match_select (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfms_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bfms_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Offer items.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // offer_format [5:0], offer_width [18:6], offer_height [31:19],
    // offer_rate [49:32], zero padding [55:50]
    input  logic [bfms_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                               s_axis_tlast,
    // Result items.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // match_position [7:0]
    output logic [bfms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // match_found [0]
    output logic                               m_axis_tuser
);

    import bfms_pkg::*;

    // Request registers.
    logic [FMT_W-1:0]  want_format_reg;
    logic [DIM_W-1:0]  want_width_reg;
    logic [DIM_W-1:0]  want_height_reg;
    logic [RATE_W-1:0] want_rate_reg;

    // Input register.
    logic              in_valid_reg;
    logic              in_valid_next;
    logic              in_last_reg;
    logic [FMT_W-1:0]  in_format_reg;
    logic [DIM_W-1:0]  in_width_reg;
    logic [DIM_W-1:0]  in_height_reg;
    logic [RATE_W-1:0] in_rate_reg;

    // Running best of the current list.
    logic              have_best_reg;
    logic              have_best_next;
    logic [POS_W-1:0]  best_position_reg;
    logic [DIM_W-1:0]  best_height_gap_reg;
    logic [DIM_W-1:0]  best_width_gap_reg;
    logic [RATE_W-1:0] best_rate_gap_reg;
    logic [POS_W-1:0]  item_position_reg;
    logic [POS_W-1:0]  item_position_next;

    // Output register.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_found_reg;
    logic [POS_W-1:0]  out_position_reg;

    logic              s_accept;
    logic              out_free;
    logic              fire;
    logic              fmt_hit;
    logic [DIM_W-1:0]  height_gap;
    logic [DIM_W-1:0]  width_gap;
    logic [RATE_W-1:0] rate_gap;
    logic              better;
    logic              take;
    logic              found;
    logic [POS_W-1:0]  win_position;

    // Configuration writes; indexes past the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_format_reg <= WANT_FORMAT_RST;
            want_width_reg  <= WANT_WIDTH_RST;
            want_height_reg <= WANT_HEIGHT_RST;
            want_rate_reg   <= WANT_RATE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WANT_FORMAT: want_format_reg <= cfg_data[FMT_W-1:0];
                REG_WANT_WIDTH:  want_width_reg  <= cfg_data[DIM_W-1:0];
                REG_WANT_HEIGHT: want_height_reg <= cfg_data[DIM_W-1:0];
                REG_WANT_RATE:   want_rate_reg   <= cfg_data[RATE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: a last offer may only move on when the output slot is free.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_valid_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_format_reg <= s_axis_tdata[FMT_W-1:0];
            in_width_reg  <= s_axis_tdata[FMT_W+DIM_W-1:FMT_W];
            in_height_reg <= s_axis_tdata[FMT_W+2*DIM_W-1:FMT_W+DIM_W];
            in_rate_reg   <= s_axis_tdata[IN_FIELDS_W-1:FMT_W+2*DIM_W];
            in_last_reg   <= s_axis_tlast;
        end
    end

    // Gaps of the held offer against the request.
    assign fmt_hit    = (in_format_reg == want_format_reg);
    assign height_gap = (in_height_reg >= want_height_reg) ? in_height_reg - want_height_reg
                                                           : want_height_reg - in_height_reg;
    assign width_gap  = (in_width_reg >= want_width_reg) ? in_width_reg - want_width_reg
                                                         : want_width_reg - in_width_reg;
    assign rate_gap   = (in_rate_reg >= want_rate_reg) ? in_rate_reg - want_rate_reg
                                                       : want_rate_reg - in_rate_reg;

    // Ordered key compare; a strict improvement is needed to replace the best.
    assign better = !have_best_reg
                  || (height_gap < best_height_gap_reg)
                  || ((height_gap == best_height_gap_reg)
                      && ((width_gap < best_width_gap_reg)
                          || ((width_gap == best_width_gap_reg)
                              && (rate_gap < best_rate_gap_reg))));
    assign take   = fmt_hit && better;

    // Outcome of the list if this offer is its last.
    assign found        = have_best_reg || take;
    assign win_position = take ? item_position_reg : best_position_reg;

    // List state: update on each offer, clear after the last one.
    always_comb
    begin
        have_best_next     = have_best_reg;
        item_position_next = item_position_reg;
        if (fire)
        begin
            if (in_last_reg)
            begin
                have_best_next     = 1'b0;
                item_position_next = '0;
            end
            else
            begin
                have_best_next = found;
                if (item_position_reg < POS_CAP)
                begin
                    item_position_next = item_position_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg     <= 1'b0;
            item_position_reg <= '0;
        end
        else
        begin
            have_best_reg     <= have_best_next;
            item_position_reg <= item_position_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && take)
        begin
            best_position_reg   <= item_position_reg;
            best_height_gap_reg <= height_gap;
            best_width_gap_reg  <= width_gap;
            best_rate_gap_reg   <= rate_gap;
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_last_reg)
        begin
            out_found_reg    <= found;
            out_position_reg <= found ? win_position : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_position_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

FILE: rtl/bfms_checker.sv
// ----------------------------------------------------------------------------
// bfms_checker
// Port-level checks of the format match block, bound to its top level.
// ----------------------------------------------------------------------------
`include "best_format_match_select_defines.svh"

module bfms_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               s_axis_tlast,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // match_position [7:0]
    input  logic [bfms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // match_found [0]
    input  logic                               m_axis_tuser
);

    import bfms_pkg::*;

    // A stalled result keeps its valid and its payload.
    `BFMS_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result changed")

    // With no matching offer the position reads zero.
    `BFMS_ASSERT_SAME(a_empty_position, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata == OUT_TDATA_W'(0), "position nonzero without a match")

    // A fresh result follows an accepted last offer through the input and output registers.
    `BFMS_ASSERT_SAME(a_result_latency, $rose(m_axis_tvalid),
        $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2),
        "result without a last offer two cycles before")

    // Offers are held back only by a pending, stalled result.
    `BFMS_ASSERT_SAME(a_stall_cause, !s_axis_tready,
        m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

endmodule

bind best_format_match_select bfms_checker u_bfms_checker (.*);
